[sv/lru_kvc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Request mode codes and fixed field widths shared by the cache.
// ----------------------------------------------------------------------------
package lru_kvc_pkg;

  // width of the request mode field
  localparam int unsigned MODE_W = 2;

  // width of the capacity register
  localparam int unsigned CAP_W = 5;

  // width of the result flags carried in tuser
  localparam int unsigned FLAG_W = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

[sv/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The cache takes one request item per clock while the result side keeps up,
// and returns one result item for each request: the request lands in an input
// register, then one pass of logic (parallel key compare over all entries,
// free-slot pick, age update) writes the result register and the entry store
// at the same edge. Back-to-back requests see each other's updates. Each
// entry carries an age that is its rank in recency order; the least recent
// entry is the one whose age equals the occupancy minus one. A result that
// waits in the output register lets a request into an empty input register,
// then holds it there until the result is taken. The store is empty after
// reset and needs no clearing pass. Capacity writes are always taken and
// belong to idle periods; zero acts as one and above ENTRIES as ENTRIES.
module lru_key_value_cache
  import lru_kvc_pkg::*;
#(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  // capacity register write channel
  input  logic                                            cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  logic [CAP_W-1:0]                                cfg_data_i,
  // request stream
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // tdata: lookup_key, write_data (lowest bit up), zero padded to bytes
  input  logic [((KEY_BITS+DATA_BITS+7)/8)*8-1:0]         s_axis_tdata,
  // tuser: mode
  input  logic [MODE_W-1:0]                               s_axis_tuser,
  // result stream
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // tdata: read_data, zero padded to bytes
  output logic [((DATA_BITS+7)/8)*8-1:0]                  m_axis_tdata,
  // tuser: hit, evicted (lowest bit up)
  output logic [FLAG_W-1:0]                               m_axis_tuser
);

  localparam int unsigned OUT_W = ((DATA_BITS + 7) / 8) * 8;
  localparam int unsigned AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // configuration
  logic [CAP_W-1:0]     cap_q;

  // input register
  logic                 in_valid_q;
  logic [MODE_W-1:0]    mode_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] data_q;

  // entry store
  logic [KEY_BITS-1:0]  keys_q [ENTRIES];
  logic [DATA_BITS-1:0] vals_q [ENTRIES];
  logic [ENTRIES-1:0]   valid_q;
  logic [AGE_W-1:0]     age_q  [ENTRIES];
  logic [CNT_W-1:0]     occ_q;

  // result register
  logic                 out_valid_q;
  logic                 res_hit_q;
  logic                 res_evict_q;
  logic [DATA_BITS-1:0] res_data_q;

  logic                 advance;

  // one request moves into the result register when that register frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // ----- lookup logic ------------------------------------------------------
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   oldest_oh;
  logic [ENTRIES-1:0]   free_oh;
  logic                 hit_any;
  logic [DATA_BITS-1:0] hit_data;
  logic [AGE_W-1:0]     hit_age;
  logic [AGE_W-1:0]     occ_m1;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     eff_cap;
  logic                 full;

  assign occ_m1 = AGE_W'(occ_q - CNT_W'(1));

  // compare every entry against the request key; ages pick the oldest
  always_comb begin
    hit_data = '0;
    hit_age  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid_q[i] && (keys_q[i] == key_q);
      oldest_oh[i] = valid_q[i] && (age_q[i] == occ_m1);
      if (match[i]) begin
        hit_data = hit_data | vals_q[i];
        hit_age  = hit_age | age_q[i];
      end
    end
  end

  assign hit_any = |match;

  // lowest free slot as a one-hot vector
  assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));

  // clamp capacity to the range 1 .. ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end

  assign full = CMP_W'(occ_q) >= eff_cap;

  // ----- request decode ----------------------------------------------------
  logic                 res_hit;
  logic                 res_evict;
  logic [DATA_BITS-1:0] res_data;
  logic [ENTRIES-1:0]   tgt_oh;
  logic [AGE_W:0]       old_age;
  logic                 do_promote;
  logic                 wr_key;
  logic                 wr_val;
  logic                 do_fill;

  always_comb begin
    res_hit    = 1'b0;
    res_evict  = 1'b0;
    res_data   = '0;
    tgt_oh     = '0;
    old_age    = '0;
    do_promote = 1'b0;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    do_fill    = 1'b0;
    case (mode_q)
      MODE_LOOKUP: begin
        if (hit_any) begin
          res_hit    = 1'b1;
          res_data   = hit_data;
          tgt_oh     = match;
          old_age    = {1'b0, hit_age};
          do_promote = 1'b1;
        end
      end
      MODE_PROBE: begin
        res_hit = hit_any;
      end
      MODE_INSERT: begin
        do_promote = 1'b1;
        wr_val     = 1'b1;
        if (hit_any) begin
          // rewrite data in place
          res_hit = 1'b1;
          tgt_oh  = match;
          old_age = {1'b0, hit_age};
        end else if (full) begin
          // replace the least recent entry
          res_evict = 1'b1;
          tgt_oh    = oldest_oh;
          old_age   = {1'b0, occ_m1};
          wr_key    = 1'b1;
        end else begin
          // take a free slot; every valid entry grows older
          tgt_oh  = free_oh;
          old_age = (AGE_W+1)'(ENTRIES);
          wr_key  = 1'b1;
          do_fill = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ----- registers ---------------------------------------------------------

  // hold capacity, input and result valid, entry valid bits and ages, occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (advance && do_promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tgt_oh[i]) begin
            age_q[i] <= '0;
          end else if (valid_q[i] && ({1'b0, age_q[i]} < old_age)) begin
            age_q[i] <= AGE_W'(age_q[i] + 1'b1);
          end
        end
      end
      if (advance && do_fill) begin
        valid_q <= valid_q | tgt_oh;
        occ_q   <= CNT_W'(occ_q + 1'b1);
      end
    end
  end

  // capture the request payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mode_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[KEY_BITS-1:0];
      data_q <= s_axis_tdata[KEY_BITS +: DATA_BITS];
    end
  end

  // load the result item
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_hit_q   <= res_hit;
      res_evict_q <= res_evict;
      res_data_q  <= res_data;
    end
  end

  // write keys and values into the target slot
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt_oh[i]) begin
          if (wr_key) begin
            keys_q[i] <= key_q;
          end
          if (wr_val) begin
            vals_q[i] <= data_q;
          end
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(res_data_q);
  assign m_axis_tuser  = {res_evict_q, res_hit_q};

  // ----- assertions --------------------------------------------------------

  // occupancy matches the number of valid entries
  a_occ_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match valid entries");

  // occupancy never exceeds the entry count
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= ENTRIES)
    else $error("occupancy above entry count");

  // an eviction is never reported together with a hit
  a_evict_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("eviction reported on a hit");

  // at most one entry holds the request key
  a_match_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> $onehot0(match))
    else $error("duplicate key in store");

  // filling a free slot raises occupancy by one
  a_fill_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && do_fill) |=> (occ_q == CNT_W'($past(occ_q) + 1'b1)))
    else $error("fill did not advance occupancy");

endmodule

[tb/sv/tb_lru_key_value_cache.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Streams lookup, probe, insert and ignored requests through the cache under
// a range of capacity settings and checks every result item field by field
// against a behavioral LRU store kept alongside the stream. Both stream sides
// idle in random bursts, and the result side holds off once for a long
// stretch so the cache backs up into its request side.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lru_kvc_pkg::*;

  localparam int unsigned SLOTS           = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned RESULT_LATENCY  = 2;
  localparam int unsigned PRESSURE_AT     = 200;
  localparam int unsigned PRESSURE_CYCLES = 48;
  localparam int unsigned IDLE_LIMIT      = 1000;
  localparam int unsigned REPORT_MAX      = 10;
  // mode code the cache ignores
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } cache_req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] rdata;
    logic              evicted;
  } cache_rsp_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CAP_W-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata: lookup_key, write_data (lowest bit up)
  logic [KEY_W+DATA_W-1:0] s_axis_tdata = '0;
  // tuser: mode
  logic [MODE_W-1:0]   s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata: read_data
  logic [DATA_W-1:0]   m_axis_tdata;
  // tuser: hit, evicted (lowest bit up)
  logic [FLAG_W-1:0]   m_axis_tuser;

  lru_key_value_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow LRU store
  logic [KEY_W-1:0]  slot_key  [SLOTS];
  logic [DATA_W-1:0] slot_val  [SLOTS];
  bit                slot_used [SLOTS];
  int unsigned       slot_rank [SLOTS];
  int unsigned       fill_count;
  logic [CAP_W-1:0]  cap_setting;

  cache_req_t req_pending [$];
  cache_rsp_t rsp_expected [$];

  // Progress and pacing
  int unsigned n_pushed;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_failures;
  int unsigned hit_total;
  int unsigned evict_total;
  int unsigned cap_writes;
  int unsigned gap_pct;
  int unsigned stall_pct;

  // Driver and monitor state
  cache_req_t  req_held;
  bit          req_loaded;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          pressure_done;
  bit          stall_now;

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Make slot s most recent; valid slots younger than its old rank age by one
  function automatic void make_recent(int s, int unsigned old_rank);
    for (int i = 0; i < SLOTS; i++) begin
      if (i != s && slot_used[i] && slot_rank[i] < old_rank) begin
        slot_rank[i]++;
      end
    end
    slot_rank[s] = 0;
  endfunction

  // Apply one request to the shadow store and return the result it yields
  function automatic cache_rsp_t lru_apply(cache_req_t req);
    cache_rsp_t  rsp;
    int          slot;
    int          oldest;
    int          free_slot;
    int unsigned room;
    rsp  = '0;
    slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == req.key) begin
        slot = i;
      end
    end
    room = (cap_setting == 0) ? 1 : ((cap_setting > SLOTS) ? SLOTS : cap_setting);
    case (req.mode)
      MODE_LOOKUP: begin
        if (slot >= 0) begin
          rsp.hit   = 1'b1;
          rsp.rdata = slot_val[slot];
          make_recent(slot, slot_rank[slot]);
        end
      end
      MODE_PROBE: begin
        rsp.hit = (slot >= 0);
      end
      MODE_INSERT: begin
        if (slot >= 0) begin
          // rewrite in place, no eviction
          rsp.hit        = 1'b1;
          slot_val[slot] = req.data;
          make_recent(slot, slot_rank[slot]);
        end else if (fill_count >= room) begin
          oldest = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest])) begin
              oldest = i;
            end
          end
          if (oldest >= 0) begin
            rsp.evicted      = 1'b1;
            slot_key[oldest] = req.key;
            slot_val[oldest] = req.data;
            make_recent(oldest, slot_rank[oldest]);
          end
        end else begin
          free_slot = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (free_slot < 0 && !slot_used[i]) begin
              free_slot = i;
            end
          end
          if (free_slot >= 0) begin
            make_recent(free_slot, SLOTS);
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot]  = req.key;
            slot_val[free_slot]  = req.data;
            fill_count++;
          end
        end
      end
      default: begin
      end
    endcase
    if (rsp.hit) hit_total++;
    if (rsp.evicted) evict_total++;
    return rsp;
  endfunction

  task automatic note_failure(string msg);
    n_failures++;
    if (n_failures <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Request driver: hold an item until accepted, then predict its result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rsp_expected.push_back(lru_apply(req_held));
        req_loaded = 1'b0;
        n_sent++;
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (!req_loaded && req_pending.size() != 0) begin
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 4);
        end else begin
          req_held   = req_pending.pop_front();
          req_loaded = 1'b1;
        end
      end
      s_axis_tvalid <= req_loaded;
      s_axis_tdata  <= {req_held.data, req_held.key};
      s_axis_tuser  <= req_held.mode;
    end
  end

  // Result monitor: check each accepted item, then pace tready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rsp_expected.size() == 0) begin
          note_failure($sformatf("result with nothing expected: hit=%0b data=%h evicted=%0b",
                                 m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]));
        end else begin
          if (m_axis_tuser[0] !== rsp_expected[0].hit) begin
            note_failure($sformatf("hit expected %0b actual %0b",
                                   rsp_expected[0].hit, m_axis_tuser[0]));
          end
          if (m_axis_tdata !== rsp_expected[0].rdata) begin
            note_failure($sformatf("read_data expected %h actual %h",
                                   rsp_expected[0].rdata, m_axis_tdata));
          end
          if (m_axis_tuser[1] !== rsp_expected[0].evicted) begin
            note_failure($sformatf("evicted expected %0b actual %0b",
                                   rsp_expected[0].evicted, m_axis_tuser[1]));
          end
          void'(rsp_expected.pop_front());
          n_checked++;
        end
      end
      stall_now = 1'b0;
      if (hold_left != 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (!pressure_done && n_sent >= PRESSURE_AT) begin
        // long hold-off so the cache backs up into its request side
        hold_left     = PRESSURE_CYCLES - 1;
        pressure_done = 1'b1;
        stall_now     = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 4);
        stall_now  = 1'b1;
      end
      m_axis_tready <= !stall_now;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] timeout: %0d of %0d results seen", $realtime, n_checked, n_pushed);
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_req(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                          logic [DATA_W-1:0] data);
    cache_req_t req;
    req.mode = mode;
    req.key  = key;
    req.data = data;
    req_pending.push_back(req);
    n_pushed++;
  endtask

  // Wait until every result is back, plus the pipeline depth
  task automatic wait_drained();
    while (n_checked != n_pushed) @(posedge clk_i);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_setting = value;
    cap_writes++;
  endtask

  task automatic set_pace(int unsigned gap, int unsigned stall);
    gap_pct   <= gap;
    stall_pct <= stall;
    @(posedge clk_i);
  endtask

  // Random requests over a small key pool so hits and evictions are common
  task automatic run_random(int unsigned count, int unsigned pool_n);
    logic [KEY_W-1:0]  key_pool [32];
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    int unsigned       pick;
    for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      mode = MODE_INSERT;
      else if (pick < 72) mode = MODE_LOOKUP;
      else if (pick < 96) mode = MODE_PROBE;
      else                mode = MODE_IGNORED;
      key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 5)       data = '0;
      else if (pick < 10) data = '1;
      else                data = $urandom;
      push_req(mode, key, data);
    end
    wait_drained();
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned cap_pick;
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
    fill_count  = 0;
    cap_setting = CAP_RESET;
    gap_pct     = 10;
    stall_pct   = 10;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, extreme keys and data, in-place update, ignored mode
    push_req(MODE_LOOKUP,  32'h0000_0000, 32'h0000_0000);
    push_req(MODE_PROBE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(MODE_INSERT,  32'h0000_0000, 32'hFFFF_FFFF);
    push_req(MODE_INSERT,  32'hFFFF_FFFF, 32'h0000_0000);
    push_req(MODE_LOOKUP,  32'h0000_0000, 32'h0000_0000);
    push_req(MODE_PROBE,   32'hFFFF_FFFF, 32'h0000_0000);
    push_req(MODE_IGNORED, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(MODE_INSERT,  32'h0000_0000, 32'h1234_5678);
    push_req(MODE_LOOKUP,  32'h0000_0000, 32'hFFFF_FFFF);
    push_req(MODE_LOOKUP,  32'h0000_0005, 32'h0000_0000);
    wait_drained();

    // full cache: probe keeps order, insert evicts the least recent
    set_capacity(5'd2);
    push_req(MODE_PROBE,   32'hFFFF_FFFF, 32'h0000_0000);
    push_req(MODE_INSERT,  32'hA5A5_A5A5, 32'h5A5A_5A5A);
    push_req(MODE_PROBE,   32'hFFFF_FFFF, 32'h0000_0000);
    push_req(MODE_LOOKUP,  32'h0000_0000, 32'h0000_0000);
    push_req(MODE_INSERT,  32'h5A5A_5A5A, 32'hA5A5_A5A5);
    push_req(MODE_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // zero capacity acts as one and sits below the current occupancy
    set_capacity(5'd0);
    push_req(MODE_INSERT,  32'h0000_0001, 32'hDEAD_BEEF);
    push_req(MODE_INSERT,  32'h0000_0002, 32'hCAFE_F00D);
    push_req(MODE_LOOKUP,  32'h0000_0001, 32'h0000_0000);
    push_req(MODE_INSERT,  32'h0000_0001, 32'h0F0F_0F0F);
    push_req(MODE_LOOKUP,  32'h0000_0002, 32'h0000_0000);
    wait_drained();

    // random phases across the capacity range
    set_capacity(5'd31);
    run_random(60, 24);
    set_capacity(5'd1);
    set_pace(30, 0);
    run_random(45, 3);
    set_capacity(5'd4);
    set_pace(0, 30);
    run_random(55, 8);
    set_capacity(5'd17);
    set_pace(10, 10);
    run_random(60, 24);
    set_capacity(5'd3);
    run_random(50, 8);
    cap_pick = $urandom_range(1, 16);
    set_capacity(cap_pick[CAP_W-1:0]);
    run_random(55, cap_pick + 4);
    set_capacity(5'd16);
    set_pace(30, 30);
    run_random(60, 20);

    // closing stretch without idling on either side
    set_capacity(5'd8);
    set_pace(0, 0);
    run_random(60, 12);
    repeat (4 * RESULT_LATENCY) @(posedge clk_i);

    if (rsp_expected.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", rsp_expected.size()));
    end
    $display("Covered %0d requests: %0d hits, %0d evictions, %0d capacity writes.",
             n_sent, hit_total, evict_total, cap_writes);
    $display("Checked %0d result items, %0d failures.", n_checked, n_failures);
    if (n_failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
